// ----- rtl/xcs_pkg.sv -----
// Shared types and constants of the XMODEM-CRC sender control.
package xcs_pkg;

    localparam int PAYLOAD_BYTES_DEF = 128;

    localparam int IMAGE_W   = 24;
    localparam int RETRY_W   = 8;
    localparam int BLOCKS_W  = 18;
    localparam int INDEX_W   = 17;
    localparam int PACKET_W  = 8;
    localparam int BYTE_W    = 8;

    localparam logic [BYTE_W-1:0] BYTE_ACK = 8'h06;
    localparam logic [BYTE_W-1:0] BYTE_NAK = 8'h15;
    localparam logic [BYTE_W-1:0] BYTE_CAN = 8'h18;
    localparam logic [BYTE_W-1:0] BYTE_C   = 8'h43;

    localparam logic [IMAGE_W-1:0] RESET_IMAGE_BYTES = 24'd1;
    localparam logic [RETRY_W-1:0] RESET_MAX_RETRIES = 8'd15;

    typedef enum logic [0:0] {
        REG_IMAGE_BYTES = 1'b0,
        REG_MAX_RETRIES = 1'b1
    } t_reg_index;

    typedef enum logic [2:0] {
        ACT_WAIT = 3'd0,
        ACT_DATA = 3'd1,
        ACT_EOT  = 3'd2,
        ACT_OK   = 3'd3,
        ACT_FAIL = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_DATA = 2'd1,
        PH_EOT  = 2'd2
    } t_phase;

    typedef struct packed {
        t_phase               phase;
        logic [BLOCKS_W-1:0]  blocks_sent;
        logic [PACKET_W-1:0]  current_packet;
        logic [RETRY_W-1:0]   retries_left;
    } t_state;

    typedef struct packed {
        t_action              action;
        logic [PACKET_W-1:0]  packet_number;
        logic [INDEX_W-1:0]   block_index;
    } t_cmd;

endpackage

// ----- rtl/xcs_if.sv -----
// Handshake channels of the XMODEM-CRC sender control.
interface xcs_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] received_byte;

    modport source (output valid, output received_byte, input ready);
    modport sink   (input valid, input received_byte, output ready);
endinterface

interface xcs_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [7:0]  packet_number;
    logic [16:0] block_index;

    modport source (output valid, output action, output packet_number, output block_index,
                    input ready);
    modport sink   (input valid, input action, input packet_number, input block_index,
                    output ready);
endinterface

interface xcs_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [23:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/xmodem_crc_sender_control.sv -----
// Top level of the XMODEM-CRC sender control.
// A byte beat enters the input register; its command is presented from the
// command register. Throughput: one byte beat per cycle while commands are
// taken; both registers let a new beat in while a finished command waits.
// Reset (synchronous, active low) returns the session to idle, loads the
// image length with 1 and the retry budget with 15, and empties both stages.
module xmodem_crc_sender_control #(
    parameter int PAYLOAD_BYTES = xcs_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    xcs_byte_if.sink    i_byte,
    xcs_cfg_if.sink     i_cfg,
    xcs_cmd_if.source   o_cmd
);
    import xcs_pkg::*;

    logic [IMAGE_W-1:0] r_image_bytes;
    logic [RETRY_W-1:0] r_max_retries;
    t_state             r_state;
    t_state             n_state;
    logic               r_in_valid;
    logic [BYTE_W-1:0]  r_in_byte;
    logic               r_out_valid;
    t_cmd               r_cmd;
    t_cmd               n_cmd;
    logic               w_advance;
    t_reg_index         w_cfg_index;

    assign w_advance   = !r_out_valid || o_cmd.ready;
    assign i_byte.ready = !r_in_valid || w_advance;
    assign i_cfg.ready  = 1'b1;
    assign w_cfg_index  = t_reg_index'(i_cfg.index);

    xcs_decide #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES)
    ) u_decide (
        .i_byte        (r_in_byte),
        .i_state       (r_state),
        .i_image_bytes (r_image_bytes),
        .i_max_retries (r_max_retries),
        .o_state       (n_state),
        .o_cmd         (n_cmd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_bytes <= RESET_IMAGE_BYTES;
            r_max_retries <= RESET_MAX_RETRIES;
        end else if (i_cfg.valid) begin
            unique case (w_cfg_index)
                REG_IMAGE_BYTES: r_image_bytes <= i_cfg.data;
                REG_MAX_RETRIES: r_max_retries <= i_cfg.data[RETRY_W-1:0];
                default:         r_image_bytes <= r_image_bytes;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.ready) begin
            r_in_valid <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.ready && i_byte.valid) begin
            r_in_byte <= i_byte.received_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase          <= PH_IDLE;
            r_state.blocks_sent    <= '0;
            r_state.current_packet <= '0;
            r_state.retries_left   <= RESET_MAX_RETRIES;
            r_out_valid            <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_in_valid) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_cmd.valid         = r_out_valid;
    assign o_cmd.action        = r_cmd.action;
    assign o_cmd.packet_number = r_cmd.packet_number;
    assign o_cmd.block_index   = r_cmd.block_index;

endmodule

// ----- rtl/xcs_decide.sv -----
// Next-state and command decision for one received byte.
module xcs_decide #(
    parameter int PAYLOAD_BYTES = xcs_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic [7:0]     i_byte,
    input  xcs_pkg::t_state i_state,
    input  logic [23:0]    i_image_bytes,
    input  logic [7:0]     i_max_retries,
    output xcs_pkg::t_state o_state,
    output xcs_pkg::t_cmd   o_cmd
);
    import xcs_pkg::*;

    localparam int PAY_W = $clog2(PAYLOAD_BYTES + 1);
    localparam int PROD_W = BLOCKS_W + PAY_W;
    localparam logic [PAY_W-1:0] PAY = PAY_W'(PAYLOAD_BYTES);

    logic [PROD_W-1:0]   w_bytes_covered;
    logic                w_all_sent;
    logic                w_active;
    logic                w_exhausted;
    logic [RETRY_W-1:0]  w_retry_dec;
    logic [PACKET_W-1:0] w_next_packet;
    logic [BLOCKS_W-1:0] w_prev_block;
    t_state              w_idle_state;

    // All blocks are out once the sent blocks cover the image length.
    assign w_bytes_covered = PROD_W'(i_state.blocks_sent) * PROD_W'(PAY);
    assign w_all_sent      = w_bytes_covered >= PROD_W'(i_image_bytes);
    assign w_active        = (i_state.phase == PH_DATA) || (i_state.phase == PH_EOT);
    assign w_exhausted     = i_state.retries_left <= RETRY_W'(1);
    assign w_retry_dec     = w_exhausted ? '0 : i_state.retries_left - RETRY_W'(1);
    assign w_next_packet   = i_state.current_packet + PACKET_W'(1);
    assign w_prev_block    = i_state.blocks_sent - BLOCKS_W'(1);

    always_comb begin
        w_idle_state.phase          = PH_IDLE;
        w_idle_state.blocks_sent    = '0;
        w_idle_state.current_packet = '0;
        w_idle_state.retries_left   = i_max_retries;

        o_state             = i_state;
        o_cmd.action        = ACT_WAIT;
        o_cmd.packet_number = '0;
        o_cmd.block_index   = '0;

        if (i_byte == BYTE_CAN) begin
            o_state      = w_idle_state;
            o_cmd.action = ACT_FAIL;
        end else if (!w_active) begin
            if (i_byte == BYTE_C) begin
                o_state.phase          = PH_DATA;
                o_state.blocks_sent    = BLOCKS_W'(1);
                o_state.current_packet = PACKET_W'(1);
                o_state.retries_left   = i_max_retries;
                o_cmd.action           = ACT_DATA;
                o_cmd.packet_number    = PACKET_W'(1);
            end else if (i_byte == BYTE_ACK || i_byte == BYTE_NAK || w_exhausted) begin
                o_state      = w_idle_state;
                o_cmd.action = ACT_FAIL;
            end else begin
                o_state.retries_left = w_retry_dec;
            end
        end else if (i_byte == BYTE_C) begin
            o_cmd.action = ACT_WAIT;
        end else if (i_byte == BYTE_ACK) begin
            if (i_state.phase == PH_EOT) begin
                o_state      = w_idle_state;
                o_cmd.action = ACT_OK;
            end else if (w_all_sent) begin
                o_state.phase        = PH_EOT;
                o_state.retries_left = i_max_retries;
                o_cmd.action         = ACT_EOT;
            end else begin
                o_state.blocks_sent    = i_state.blocks_sent + BLOCKS_W'(1);
                o_state.current_packet = w_next_packet;
                o_state.retries_left   = i_max_retries;
                o_cmd.action           = ACT_DATA;
                o_cmd.packet_number    = w_next_packet;
                o_cmd.block_index      = i_state.blocks_sent[INDEX_W-1:0];
            end
        end else if (w_exhausted) begin
            o_state      = w_idle_state;
            o_cmd.action = ACT_FAIL;
        end else begin
            o_state.retries_left = w_retry_dec;
            if (i_byte == BYTE_NAK) begin
                if (i_state.phase == PH_EOT) begin
                    o_cmd.action = ACT_EOT;
                end else begin
                    o_cmd.action        = ACT_DATA;
                    o_cmd.packet_number = i_state.current_packet;
                    o_cmd.block_index   = w_prev_block[INDEX_W-1:0];
                end
            end
        end
    end

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench of the XMODEM-CRC sender control with a session scoreboard.
`timescale 1ns / 100ps

module tb;
    import xcs_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_ITEMS = 1600;
    localparam int DRAIN_CYCLES = 8;

    logic i_clk;
    logic i_rst_n;

    xcs_byte_if byte_ch ();
    xcs_cfg_if  cfg_ch ();
    xcs_cmd_if  cmd_ch ();

    xmodem_crc_sender_control #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES_DEF)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_byte (byte_ch),
        .i_cfg  (cfg_ch),
        .o_cmd  (cmd_ch)
    );

    class sender_session_tracker;
        logic [IMAGE_W-1:0]  image_bytes;
        logic [RETRY_W-1:0]  max_retries;
        t_phase              phase;
        logic [BLOCKS_W-1:0] blocks_sent;
        logic [PACKET_W-1:0] current_packet;
        logic [RETRY_W-1:0]  retries_left;
        t_cmd                expected_cmds[$];
        int                  errors;

        function new();
            image_bytes    = RESET_IMAGE_BYTES;
            max_retries    = RESET_MAX_RETRIES;
            phase          = PH_IDLE;
            blocks_sent    = '0;
            current_packet = '0;
            retries_left   = 8'd15;
            errors         = 0;
        endfunction

        function void write_reg(t_reg_index idx, logic [IMAGE_W-1:0] data);
            if (idx == REG_IMAGE_BYTES) begin
                image_bytes = data;
            end else begin
                max_retries = data[RETRY_W-1:0];
            end
        endfunction

        function int total_blocks();
            return (int'(image_bytes) + PAYLOAD_BYTES_DEF - 1) / PAYLOAD_BYTES_DEF;
        endfunction

        function bit in_session();
            return (phase == PH_DATA) || (phase == PH_EOT);
        endfunction

        function int pending();
            return expected_cmds.size();
        endfunction

        function void end_session();
            phase          = PH_IDLE;
            blocks_sent    = '0;
            current_packet = '0;
            retries_left   = max_retries;
        endfunction

        function bit spend_retry();
            if (retries_left <= RETRY_W'(1)) begin
                retries_left = '0;
                return 1'b1;
            end
            retries_left = retries_left - RETRY_W'(1);
            return 1'b0;
        endfunction

        function void note_byte(logic [BYTE_W-1:0] b);
            t_cmd                cmd;
            logic [BLOCKS_W-1:0] last_block;
            cmd.action        = ACT_WAIT;
            cmd.packet_number = '0;
            cmd.block_index   = '0;
            last_block        = blocks_sent - BLOCKS_W'(1);
            if (b == BYTE_CAN) begin
                end_session();
                cmd.action = ACT_FAIL;
            end else if (!in_session()) begin
                if (b == BYTE_C) begin
                    phase             = PH_DATA;
                    current_packet    = 8'd1;
                    blocks_sent       = 18'd1;
                    retries_left      = max_retries;
                    cmd.action        = ACT_DATA;
                    cmd.packet_number = 8'd1;
                end else if (b == BYTE_ACK || b == BYTE_NAK) begin
                    end_session();
                    cmd.action = ACT_FAIL;
                end else if (spend_retry()) begin
                    end_session();
                    cmd.action = ACT_FAIL;
                end
            end else if (b == BYTE_C) begin
                cmd.action = ACT_WAIT;
            end else if (b == BYTE_ACK) begin
                if (phase == PH_EOT) begin
                    end_session();
                    cmd.action = ACT_OK;
                end else if (int'(blocks_sent) >= total_blocks()) begin
                    phase        = PH_EOT;
                    retries_left = max_retries;
                    cmd.action   = ACT_EOT;
                end else begin
                    cmd.block_index   = blocks_sent[INDEX_W-1:0];
                    current_packet    = current_packet + PACKET_W'(1);
                    cmd.packet_number = current_packet;
                    blocks_sent       = blocks_sent + BLOCKS_W'(1);
                    retries_left      = max_retries;
                    cmd.action        = ACT_DATA;
                end
            end else if (b == BYTE_NAK) begin
                if (spend_retry()) begin
                    end_session();
                    cmd.action = ACT_FAIL;
                end else if (phase == PH_EOT) begin
                    cmd.action = ACT_EOT;
                end else begin
                    cmd.block_index   = last_block[INDEX_W-1:0];
                    cmd.packet_number = current_packet;
                    cmd.action        = ACT_DATA;
                end
            end else if (spend_retry()) begin
                end_session();
                cmd.action = ACT_FAIL;
            end
            expected_cmds.push_back(cmd);
        endfunction

        function void check_cmd(logic [2:0] act, logic [PACKET_W-1:0] pkt,
                                logic [INDEX_W-1:0] idx);
            t_cmd exp_cmd;
            if (expected_cmds.size() == 0) begin
                $error("command beat with no command pending: action %0d", act);
                errors++;
                return;
            end
            exp_cmd = expected_cmds.pop_front();
            if (act !== exp_cmd.action) begin
                $error("action: expected %0d, got %0d", exp_cmd.action, act);
                errors++;
            end
            if (pkt !== exp_cmd.packet_number) begin
                $error("packet_number: expected %0d, got %0d", exp_cmd.packet_number, pkt);
                errors++;
            end
            if (idx !== exp_cmd.block_index) begin
                $error("block_index: expected %0d, got %0d", exp_cmd.block_index, idx);
                errors++;
            end
        endfunction
    endclass

    sender_session_tracker sessions;
    int cycle_count = 0;
    int items_sent  = 0;
    int burst_left  = 0;
    int rdy_mode    = 0;
    int rdy_left    = 0;
    int rdy_period  = 2;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (rdy_left == 0) begin
            rdy_mode   <= $urandom_range(0, 3);
            rdy_left   <= $urandom_range(32, 400);
            rdy_period <= $urandom_range(2, 8);
        end else begin
            rdy_left <= rdy_left - 1;
        end
        case (rdy_mode)
            0: begin
                cmd_ch.ready <= 1'b1;
            end
            1: begin
                cmd_ch.ready <= ($urandom_range(0, 3) != 0);
            end
            2: begin
                cmd_ch.ready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
                cmd_ch.ready <= ((cycle_count % rdy_period) != 0);
            end
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ($isunknown(cmd_ch.valid)) begin
                $error("command valid is unknown");
                sessions.errors++;
            end else if (cmd_ch.valid && cmd_ch.ready) begin
                sessions.check_cmd(cmd_ch.action, cmd_ch.packet_number, cmd_ch.block_index);
            end
        end
    end

    task automatic push_byte(input logic [BYTE_W-1:0] b);
        int gap;
        if (burst_left == 0) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    gap = 0;
                end
                9: begin
                    gap = $urandom_range(10, 30);
                end
                default: begin
                    gap = $urandom_range(1, 6);
                end
            endcase
            if (gap > 0) begin
                byte_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        byte_ch.valid         <= 1'b1;
        byte_ch.received_byte <= b;
        @(posedge i_clk);
        while (byte_ch.ready !== 1'b1) @(posedge i_clk);
        sessions.note_byte(b);
        items_sent++;
        burst_left--;
    endtask

    task automatic drain();
        byte_ch.valid <= 1'b0;
        while (sessions.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_index idx, input logic [IMAGE_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge i_clk);
        while (cfg_ch.ready !== 1'b1) @(posedge i_clk);
        sessions.write_reg(idx, data);
    endtask

    task automatic configure(input logic [IMAGE_W-1:0] image, input logic [IMAGE_W-1:0] retries);
        drain();
        write_reg(REG_IMAGE_BYTES, image);
        write_reg(REG_MAX_RETRIES, retries);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [BYTE_W-1:0] plain_byte();
        logic [BYTE_W-1:0] b;
        do begin
            b = BYTE_W'($urandom_range(0, 255));
        end while (b inside {BYTE_ACK, BYTE_NAK, BYTE_CAN, BYTE_C});
        return b;
    endfunction

    task automatic run_directed();
        push_byte(BYTE_ACK);
        push_byte(BYTE_NAK);
        push_byte(BYTE_CAN);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(BYTE_C);
        push_byte(BYTE_C);
        push_byte(BYTE_NAK);
        push_byte(8'h55);
        push_byte(BYTE_ACK);
        push_byte(BYTE_NAK);
        push_byte(BYTE_ACK);
        push_byte(BYTE_C);
        push_byte(BYTE_CAN);
        configure(24'd0, 24'd1);
        push_byte(BYTE_C);
        push_byte(BYTE_ACK);
        push_byte(BYTE_NAK);
        push_byte(8'hAA);
        configure(24'd129, 24'd255);
        push_byte(BYTE_C);
        push_byte(BYTE_ACK);
        push_byte(BYTE_ACK);
        push_byte(BYTE_ACK);
        configure(24'hFFFFFF, 24'd0);
        push_byte(BYTE_C);
        push_byte(BYTE_ACK);
        push_byte(BYTE_CAN);
    endtask

    task automatic run_session();
        int                cap;
        int                steps;
        int                r;
        logic [BYTE_W-1:0] b;
        if (sessions.in_session()) begin
            push_byte(BYTE_CAN);
        end
        cap = ($urandom_range(0, 19) == 0) ? 300 : $urandom_range(1, 20);
        push_byte(BYTE_C);
        steps = 0;
        while (sessions.in_session() && steps < 2 * cap + 8) begin
            r = $urandom_range(0, 99);
            if (r < 75) begin
                b = BYTE_ACK;
            end else if (r < 85) begin
                b = BYTE_NAK;
            end else if (r < 90) begin
                b = plain_byte();
            end else if (r < 95) begin
                b = BYTE_C;
            end else if (r < 99) begin
                b = BYTE_W'($urandom_range(0, 255));
            end else begin
                b = BYTE_CAN;
            end
            push_byte(b);
            steps++;
        end
        if (sessions.in_session()) begin
            push_byte(BYTE_CAN);
        end
    endtask

    task automatic run_noise();
        int                n;
        logic [BYTE_W-1:0] b;
        n = $urandom_range(1, 10);
        repeat (n) begin
            if ($urandom_range(0, 1) == 0) begin
                case ($urandom_range(0, 3))
                    0: b = BYTE_ACK;
                    1: b = BYTE_NAK;
                    2: b = BYTE_CAN;
                    default: b = BYTE_C;
                endcase
            end else begin
                b = BYTE_W'($urandom_range(0, 255));
            end
            push_byte(b);
        end
    endtask

    task automatic run_random();
        int                 start_items;
        int                 n;
        int                 r;
        logic [IMAGE_W-1:0] image;
        logic [IMAGE_W-1:0] retries;
        start_items = items_sent;
        while (items_sent - start_items < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                image = '0;
            end else if (r < 20) begin
                image = IMAGE_W'($urandom_range(1, 128));
            end else if (r < 70) begin
                image = IMAGE_W'($urandom_range(1, 1024));
            end else if (r < 80) begin
                image = IMAGE_W'(PAYLOAD_BYTES_DEF * $urandom_range(1, 8));
            end else if (r < 90) begin
                image = IMAGE_W'($urandom());
            end else begin
                image = 24'hFFFFFF;
            end
            retries = IMAGE_W'($urandom());
            r = $urandom_range(0, 99);
            if (r < 30) begin
                retries[RETRY_W-1:0] = RETRY_W'($urandom_range(1, 3));
            end else if (r < 40) begin
                retries[RETRY_W-1:0] = '0;
            end else if (r < 50) begin
                retries[RETRY_W-1:0] = '1;
            end
            configure(image, retries);
            n = $urandom_range(1, 4);
            repeat (n) begin
                if ($urandom_range(0, 99) < 85) begin
                    run_session();
                end else begin
                    run_noise();
                end
            end
        end
    endtask

    initial begin
        sessions              = new();
        byte_ch.valid         <= 1'b0;
        byte_ch.received_byte <= '0;
        cfg_ch.valid          <= 1'b0;
        cfg_ch.index          <= REG_IMAGE_BYTES;
        cfg_ch.data           <= '0;
        i_rst_n               <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        run_random();
        drain();
        if (sessions.pending() != 0) begin
            $error("%0d commands never arrived", sessions.pending());
            sessions.errors++;
        end
        if (sessions.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
